@@ sv/sm3_pkg.sv @@
// SM3 engine package: IV, round constants, word functions and the front-to-back
// command type. No dependencies.
package sm3_pkg;

   localparam int WordW      = 32;
   localparam int BlockWords = 16;
   localparam int Rounds     = 64;
   localparam int FifoDepth  = 4;
   localparam int ByteCntW   = 61;

   localparam logic [31:0] TLow  = 32'h79cc4519;
   localparam logic [31:0] THigh = 32'h7a879d8a;
   localparam logic [7:0]  PadMark = 8'h80;

   localparam logic [31:0] Iv [8] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };

   // Word pushed from the front to the back, with the digest request on the
   // final length word.
   typedef struct packed {
      logic [31:0] word;
      logic        finish;
   } sm3_cmd_type;

   function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
   endfunction

endpackage

@@ sv/sm3_front.sv @@
// SM3 front end: takes message words, keeps the byte count and issues the
// padded word stream (0x80, zeros, 64-bit length). Uses sm3_pkg.
module sm3_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [31:0]         req_message_word,
   input  logic [2:0]          req_valid_bytes,
   input  logic                req_is_last,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output sm3_pkg::sm3_cmd_type cmd
);
   import sm3_pkg::*;

   typedef enum logic [2:0] {
      ST_TAKE, ST_MARK, ST_ZERO, ST_LEN_HI, ST_LEN_LO
   } state_type;

   state_type             state_ff;
   logic [ByteCntW-1:0]   count_ff;
   logic [3:0]            pos_ff;      // words issued in the current block

   logic [2:0]            vb;
   logic [ByteCntW-1:0]   count_in;
   logic [31:0]           kept;
   logic [63:0]           bits;

   assign vb        = (req_valid_bytes > 3'd4) ? 3'd4 : req_valid_bytes;
   assign req_ready = (state_ff == ST_TAKE) && cmd_ready;
   assign count_in  = count_ff + (req_is_last ? ByteCntW'(vb) : ByteCntW'(4));
   assign bits      = {count_ff, 3'b000};

   always_comb begin
      case (vb)
         3'd0:    kept = {PadMark, 24'h0};
         3'd1:    kept = {req_message_word[31:24], PadMark, 16'h0};
         3'd2:    kept = {req_message_word[31:16], PadMark, 8'h0};
         3'd3:    kept = {req_message_word[31:8], PadMark};
         default: kept = req_message_word;
      endcase
   end

   always_comb begin
      cmd_valid  = 1'b0;
      cmd.word   = '0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_TAKE: begin
            cmd_valid = req_valid;
            cmd.word  = req_is_last ? kept : req_message_word;
         end
         ST_MARK: begin
            cmd_valid = 1'b1;
            cmd.word  = {PadMark, 24'h0};
         end
         ST_ZERO:   cmd_valid = 1'b1;
         ST_LEN_HI: begin
            cmd_valid = 1'b1;
            cmd.word  = bits[63:32];
         end
         ST_LEN_LO: begin
            cmd_valid  = 1'b1;
            cmd.word   = bits[31:0];
            cmd.finish = 1'b1;
         end
         default: cmd_valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TAKE;
         count_ff <= '0;
         pos_ff   <= '0;
      end else if (cmd_valid && cmd_ready) begin
         pos_ff <= pos_ff + 4'd1;
         case (state_ff)
            ST_TAKE: begin
               count_ff <= count_in;
               if (req_is_last) begin
                  if (vb == 3'd4)             state_ff <= ST_MARK;
                  else if (pos_ff == 4'd13)   state_ff <= ST_LEN_HI;
                  else                        state_ff <= ST_ZERO;
               end
            end
            ST_MARK:
               state_ff <= (pos_ff == 4'd13) ? ST_LEN_HI : ST_ZERO;
            ST_ZERO:
               if (pos_ff == 4'd13) state_ff <= ST_LEN_HI;
            ST_LEN_HI: state_ff <= ST_LEN_LO;
            ST_LEN_LO: begin
               state_ff <= ST_TAKE;
               count_ff <= '0;
            end
            default: state_ff <= ST_TAKE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_ready && cmd.finish) |-> (pos_ff == 4'd15))
      else $error("length word not at end of block");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN_HI) |-> (pos_ff == 4'd14))
      else $error("length high word misplaced");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_TAKE) |-> !req_ready)
      else $error("input taken during padding");

endmodule

@@ sv/sm3_fifo.sv @@
// Short item queue between SM3 front and back. Uses sm3_pkg.
module sm3_fifo #(
   parameter int Depth = sm3_pkg::FifoDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sm3_pkg::sm3_cmd_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sm3_pkg::sm3_cmd_type out_data
);
   import sm3_pkg::*;

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   sm3_cmd_type      mem_ff [Depth];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [AW:0]      cnt_ff;
   logic             push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(Depth);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(Depth)) else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count slip");
   assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("queue count slip");

endmodule

@@ sv/sm3_back.sv @@
// SM3 back end: block buffer, 64-round compression at one round per cycle
// with a 16-word expansion window, chaining value and digest output.
// Uses sm3_pkg.
module sm3_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  sm3_pkg::sm3_cmd_type cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_digest_word,
   output logic                 rsp_digest_last
);
   import sm3_pkg::*;

   typedef enum logic [1:0] {ST_FILL, ST_ROUND, ST_OUT} state_type;

   state_type     state_ff;
   logic [31:0]   w_ff [BlockWords];   // buffer, then expansion window
   logic [3:0]    fill_ff;
   logic [5:0]    rnd_ff;
   logic [2:0]    out_ff;
   logic          finish_ff;
   logic [31:0]   v_ff [8];
   logic [31:0]   r_ff [8];           // a..h

   logic [31:0]   wn, a12, ss1, ss2, ff, gg, tt1, tt2, tj;
   logic          take;

   assign cmd_ready       = state_ff == ST_FILL;
   assign take            = cmd_valid && cmd_ready;
   assign rsp_valid       = state_ff == ST_OUT;
   assign rsp_digest_word = v_ff[out_ff];
   assign rsp_digest_last = out_ff == 3'd7;

   always_comb begin
      wn  = perm1(w_ff[0] ^ w_ff[7] ^ rol32(w_ff[13], 5'd15))
            ^ rol32(w_ff[3], 5'd7) ^ w_ff[10];
      tj  = (rnd_ff < 6'd16) ? TLow : THigh;
      a12 = rol32(r_ff[0], 5'd12);
      ss1 = rol32(a12 + r_ff[4] + rol32(tj, rnd_ff[4:0]), 5'd7);
      ss2 = ss1 ^ a12;
      if (rnd_ff < 6'd16) begin
         ff = r_ff[0] ^ r_ff[1] ^ r_ff[2];
         gg = r_ff[4] ^ r_ff[5] ^ r_ff[6];
      end else begin
         ff = (r_ff[0] & r_ff[1]) | (r_ff[0] & r_ff[2]) | (r_ff[1] & r_ff[2]);
         gg = (r_ff[4] & r_ff[5]) | (~r_ff[4] & r_ff[6]);
      end
      tt1 = ff + r_ff[3] + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2 = gg + r_ff[7] + ss1 + w_ff[0];
   end

   always_ff @(posedge clock) begin
      if (take) w_ff[fill_ff] <= cmd.word;
      else if (state_ff == ST_ROUND) begin
         for (int i = 0; i < BlockWords-1; i++) w_ff[i] <= w_ff[i+1];
         w_ff[BlockWords-1] <= wn;
      end
      if (take && fill_ff == 4'd15) begin
         for (int i = 0; i < 8; i++) r_ff[i] <= v_ff[i];
      end else if (state_ff == ST_ROUND) begin
         r_ff[0] <= tt1;
         r_ff[1] <= r_ff[0];
         r_ff[2] <= rol32(r_ff[1], 5'd9);
         r_ff[3] <= r_ff[2];
         r_ff[4] <= perm0(tt2);
         r_ff[5] <= r_ff[4];
         r_ff[6] <= rol32(r_ff[5], 5'd19);
         r_ff[7] <= r_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_FILL;
         fill_ff   <= '0;
         rnd_ff    <= '0;
         out_ff    <= '0;
         finish_ff <= 1'b0;
         for (int i = 0; i < 8; i++) v_ff[i] <= Iv[i];
      end else begin
         case (state_ff)
            ST_FILL:
               if (take) begin
                  fill_ff <= fill_ff + 4'd1;
                  if (fill_ff == 4'd15) begin
                     state_ff  <= ST_ROUND;
                     rnd_ff    <= '0;
                     finish_ff <= cmd.finish;
                  end
               end
            ST_ROUND: begin
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) begin
                  v_ff[0] <= v_ff[0] ^ tt1;
                  v_ff[1] <= v_ff[1] ^ r_ff[0];
                  v_ff[2] <= v_ff[2] ^ rol32(r_ff[1], 5'd9);
                  v_ff[3] <= v_ff[3] ^ r_ff[2];
                  v_ff[4] <= v_ff[4] ^ perm0(tt2);
                  v_ff[5] <= v_ff[5] ^ r_ff[4];
                  v_ff[6] <= v_ff[6] ^ rol32(r_ff[5], 5'd19);
                  v_ff[7] <= v_ff[7] ^ r_ff[6];
                  state_ff <= finish_ff ? ST_OUT : ST_FILL;
                  out_ff   <= '0;
               end
            end
            ST_OUT:
               if (rsp_ready) begin
                  out_ff <= out_ff + 3'd1;
                  if (out_ff == 3'd7) begin
                     state_ff <= ST_FILL;
                     for (int i = 0; i < 8; i++) v_ff[i] <= Iv[i];
                  end
               end
            default: state_ff <= ST_FILL;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (fill_ff == 4'd0))
      else $error("buffer count not cleared at compression");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_digest_last) |=> (state_ff == ST_FILL))
      else $error("no return to fill after digest");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (fill_ff == 4'd0))
      else $error("digest with partial block");

endmodule

@@ sv/sm3_hash_engine_unit.sv @@
// SM3 hash engine top level: front end (padding), item queue, back end
// (compression and digest). Uses sm3_pkg, sm3_front, sm3_fifo, sm3_back.
//
//  channel | direction | ports
//  req     | in        | req_valid/req_ready, message_word, valid_bytes, is_last
//  rsp     | out       | rsp_valid/rsp_ready, digest_word, digest_last
//
// Each message word is queued as it is taken; every 16th word starts 64 rounds
// at one round per cycle in the back end, which takes no words meanwhile.
// A last item adds up to 18 padding words and one or two compressions, then
// the 8 digest words. Synchronous active-high reset returns to the SM3 IV.
// Either side may stall; the queue holds up to FifoDepth words.
module sm3_hash_engine_unit #(
   parameter int FifoDepth = sm3_pkg::FifoDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_digest_last
);
   import sm3_pkg::*;

   sm3_cmd_type f_cmd, b_cmd;
   logic        f_valid, f_ready, b_valid, b_ready;

   sm3_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_message_word,
      .req_valid_bytes, .req_is_last,
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
   );

   sm3_fifo #(.Depth(FifoDepth)) u_fifo (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_cmd),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_cmd)
   );

   sm3_back u_back (
      .clock, .reset, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
      .rsp_valid, .rsp_ready, .rsp_digest_word, .rsp_digest_last
   );

endmodule
